>>> rtl/c65_pkg.sv
// Package for the 6502 instruction step block: payload words, decode types,
// sequencer states, micro-operations and the instruction execute function.
// No dependencies.
package c65_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_data;
        logic [15:0] program_counter;
        logic [7:0]  accumulator;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack_pointer;
        logic [7:0]  status_flags;
    } t_out_word;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_EXEC  = 3'd2;
    localparam logic [2:0] MODE_RESET = 3'd3;
    localparam logic [2:0] MODE_START = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_STOP = 2'd1;
    localparam logic [1:0] ST_BRK  = 2'd2;
    localparam logic [1:0] ST_JAM  = 2'd3;

    localparam logic [15:0] STOP_RESET = 16'h080C;
    localparam logic [15:0] VEC_RESET  = 16'hFFFC;
    localparam logic [15:0] VEC_BRK    = 16'hFFFE;
    localparam logic [7:0]  P_RESET    = 8'h24;
    localparam logic [7:0]  SP_START   = 8'hFD;
    localparam logic [7:0]  RET_HI     = 8'h08;
    localparam logic [7:0]  RET_LO     = 8'h0C;

    localparam logic [7:0] OP_RTS = 8'h60;
    localparam logic [7:0] OP_PHA = 8'h48;
    localparam logic [7:0] OP_PLA = 8'h68;

    typedef enum logic [3:0] {
        CL_IMPL, CL_READ, CL_STORE, CL_RMW, CL_BRANCH, CL_JMP, CL_JMPI, CL_JSR,
        CL_RTS, CL_RTI, CL_BRK, CL_PUSH, CL_PULL, CL_JAM
    } t_cls;

    typedef enum logic [3:0] {
        AM_NONE, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY,
        AM_INDX, AM_INDY
    } t_am;

    typedef struct packed {
        t_cls cls;
        t_am  am;
    } t_dec;

    typedef struct packed {
        t_cls cls;
        t_am  am;
        logic jam;
        logic at_stop;
    } t_dp_stat;

    typedef enum logic [5:0] {
        U_NONE, U_HWRITE, U_HREAD, U_HLATCH, U_JAMST, U_STOPST, U_FETCH, U_RST,
        U_VLO, U_VHI, U_VEC, U_START1, U_START2, U_IMPL, U_JAM, U_PUSH, U_POP,
        U_PULL, U_POPLO, U_POPP, U_RET, U_BRK1, U_BRK2, U_BRK3, U_BRANCH,
        U_EXEC, U_ZP, U_PTR, U_PTR2, U_PTR3, U_JMP, U_JSR1, U_JSR2, U_IND1,
        U_IND2, U_IND3, U_ABS, U_STORE, U_RDEA, U_RMW
    } t_uop;

    typedef struct packed {
        logic accept;
        logic op_load;
        t_uop uop;
    } t_dp_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_HRD, S_V1, S_V2, S_ST2, S_OP, S_PL, S_PL2, S_PH, S_BK2,
        S_BK3, S_BK4, S_B1, S_B2, S_JS2, S_I1, S_I2, S_P1, S_P2, S_ACC,
        S_OPND, S_FIN
    } t_state;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
        logic [7:0] m;
    } t_regs;

    function automatic t_am mode_of(logic [2:0] bbb, logic uses_y);
        t_am am;
        unique case (bbb)
            3'd0: am = AM_IMM;
            3'd1: am = AM_ZP;
            3'd3: am = AM_ABS;
            3'd5: am = uses_y ? AM_ZPY : AM_ZPX;
            3'd7: am = uses_y ? AM_ABSY : AM_ABSX;
            default: am = AM_NONE;
        endcase
        return am;
    endfunction

    function automatic t_dec decode(logic [7:0] op);
        t_dec d;
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic [1:0] cc;
        logic b_ld;
        logic b_st;
        aaa = op[7:5];
        bbb = op[4:2];
        cc = op[1:0];
        b_ld = (bbb == 3'd0) || (bbb == 3'd1) || (bbb == 3'd3) || (bbb == 3'd5)
            || (bbb == 3'd7);
        b_st = (bbb == 3'd1) || (bbb == 3'd3) || (bbb == 3'd5);
        d.cls = CL_JAM;
        d.am = AM_NONE;
        if (cc == 2'd1 && op != 8'h89) begin
            d.cls = (aaa == 3'd4) ? CL_STORE : CL_READ;
            unique case (bbb)
                3'd0: d.am = AM_INDX;
                3'd1: d.am = AM_ZP;
                3'd2: d.am = AM_IMM;
                3'd3: d.am = AM_ABS;
                3'd4: d.am = AM_INDY;
                3'd5: d.am = AM_ZPX;
                3'd6: d.am = AM_ABSY;
                default: d.am = AM_ABSX;
            endcase
        end else if (cc == 2'd2 && !aaa[2] && (b_st || bbb == 3'd2 || bbb == 3'd7)) begin
            d.cls = (bbb == 3'd2) ? CL_IMPL : CL_RMW;
            d.am = mode_of(bbb, 1'b0);
        end else if (cc == 2'd2 && aaa[2:1] == 2'b11 && bbb[0]) begin
            d.cls = CL_RMW;
            d.am = mode_of(bbb, 1'b0);
        end else if (cc == 2'd2 && aaa == 3'd5 && b_ld) begin
            d.cls = CL_READ;
            d.am = mode_of(bbb, 1'b1);
        end else if (cc == 2'd2 && aaa == 3'd4 && b_st) begin
            d.cls = CL_STORE;
            d.am = mode_of(bbb, 1'b1);
        end else if (cc == 2'd0 && aaa == 3'd5 && b_ld) begin
            d.cls = CL_READ;
            d.am = mode_of(bbb, 1'b0);
        end else if (cc == 2'd0 && aaa == 3'd4 && b_st) begin
            d.cls = CL_STORE;
            d.am = mode_of(bbb, 1'b0);
        end else if (cc == 2'd0 && aaa[2:1] == 2'b11
                     && (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3)) begin
            d.cls = CL_READ;
            d.am = mode_of(bbb, 1'b0);
        end else if (op[4:0] == 5'h10) begin
            d.cls = CL_BRANCH;
        end else begin
            unique case (op)
                8'h24: begin
                    d.cls = CL_READ;
                    d.am = AM_ZP;
                end
                8'h4C: begin
                    d.cls = CL_JMP;
                    d.am = AM_ABS;
                end
                8'h6C: begin
                    d.cls = CL_JMPI;
                    d.am = AM_ABS;
                end
                8'h20: begin
                    d.cls = CL_JSR;
                    d.am = AM_ABS;
                end
                8'h60: d.cls = CL_RTS;
                8'h40: d.cls = CL_RTI;
                8'h00: d.cls = CL_BRK;
                8'h48, 8'h08: d.cls = CL_PUSH;
                8'h68, 8'h28: d.cls = CL_PULL;
                8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8, 8'hAA, 8'hA8,
                8'h8A, 8'h98, 8'hBA, 8'h9A, 8'hE8, 8'hC8, 8'hCA, 8'h88,
                8'hEA: d.cls = CL_IMPL;
                default: d.cls = CL_JAM;
            endcase
        end
        return d;
    endfunction

    function automatic logic [7:0] set_zn(logic [7:0] p, logic [7:0] v);
        logic [7:0] o;
        o = p;
        o[1] = (v == 8'h00);
        o[7] = v[7];
        return o;
    endfunction

    // Register and memory effects of every opcode that works on one operand.
    function automatic t_regs exec_op(logic [7:0] op, logic [7:0] v, t_regs r);
        t_regs o;
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic [1:0] cc;
        logic [8:0] sum;
        logic [7:0] res;
        logic [7:0] cmp_r;
        o = r;
        o.m = v;
        aaa = op[7:5];
        bbb = op[4:2];
        cc = op[1:0];
        sum = '0;
        res = '0;
        cmp_r = '0;
        unique case (op)
            8'h18: o.p[0] = 1'b0;
            8'h38: o.p[0] = 1'b1;
            8'h58: o.p[2] = 1'b0;
            8'h78: o.p[2] = 1'b1;
            8'hB8: o.p[6] = 1'b0;
            8'hD8: o.p[3] = 1'b0;
            8'hF8: o.p[3] = 1'b1;
            8'hAA: begin
                o.x = r.a;
                o.p = set_zn(r.p, r.a);
            end
            8'hA8: begin
                o.y = r.a;
                o.p = set_zn(r.p, r.a);
            end
            8'h8A: begin
                o.a = r.x;
                o.p = set_zn(r.p, r.x);
            end
            8'h98: begin
                o.a = r.y;
                o.p = set_zn(r.p, r.y);
            end
            8'hBA: begin
                o.x = r.s;
                o.p = set_zn(r.p, r.s);
            end
            8'h9A: o.s = r.x;
            8'hE8: begin
                o.x = r.x + 8'd1;
                o.p = set_zn(r.p, o.x);
            end
            8'hC8: begin
                o.y = r.y + 8'd1;
                o.p = set_zn(r.p, o.y);
            end
            8'hCA: begin
                o.x = r.x - 8'd1;
                o.p = set_zn(r.p, o.x);
            end
            8'h88: begin
                o.y = r.y - 8'd1;
                o.p = set_zn(r.p, o.y);
            end
            8'hEA: o.m = v;
            8'h24: begin
                o.p[1] = ((r.a & v) == 8'h00);
                o.p[7:6] = v[7:6];
            end
            default: begin
                if (cc == 2'd1) begin
                    unique case (aaa)
                        3'd0: o.a = r.a | v;
                        3'd1: o.a = r.a & v;
                        3'd2: o.a = r.a ^ v;
                        3'd3: begin
                            sum = {1'b0, r.a} + {1'b0, v} + {8'd0, r.p[0]};
                            o.a = sum[7:0];
                            o.p[0] = sum[8];
                            o.p[6] = (~(r.a ^ v) & (r.a ^ sum[7:0])) >> 7 != 8'd0;
                        end
                        3'd4: o.m = r.a;
                        3'd5: o.a = v;
                        3'd6: begin
                            sum = {1'b0, r.a} + {1'b0, ~v} + 9'd1;
                            o.p[0] = sum[8];
                            o.p = set_zn(o.p, sum[7:0]);
                        end
                        default: begin
                            sum = {1'b0, r.a} + {1'b0, ~v} + {8'd0, r.p[0]};
                            o.a = sum[7:0];
                            o.p[0] = sum[8];
                            o.p[6] = ((r.a ^ sum[7:0]) & (r.a ^ v)) >> 7 != 8'd0;
                        end
                    endcase
                    if (aaa != 3'd4 && aaa != 3'd6) begin
                        o.p = set_zn(o.p, o.a);
                    end
                end else if (cc == 2'd2 && !aaa[2]) begin
                    unique case (aaa[1:0])
                        2'd0: begin
                            o.p[0] = v[7];
                            res = {v[6:0], 1'b0};
                        end
                        2'd1: begin
                            o.p[0] = v[7];
                            res = {v[6:0], r.p[0]};
                        end
                        2'd2: begin
                            o.p[0] = v[0];
                            res = {1'b0, v[7:1]};
                        end
                        default: begin
                            o.p[0] = v[0];
                            res = {r.p[0], v[7:1]};
                        end
                    endcase
                    o.p = set_zn(o.p, res);
                    if (bbb == 3'd2) begin
                        o.a = res;
                    end else begin
                        o.m = res;
                    end
                end else if (cc == 2'd2 && aaa[2:1] == 2'b11) begin
                    res = aaa[0] ? v + 8'd1 : v - 8'd1;
                    o.m = res;
                    o.p = set_zn(r.p, res);
                end else if (cc == 2'd2 && aaa == 3'd5) begin
                    o.x = v;
                    o.p = set_zn(r.p, v);
                end else if (cc == 2'd2) begin
                    o.m = r.x;
                end else if (aaa == 3'd5) begin
                    o.y = v;
                    o.p = set_zn(r.p, v);
                end else if (aaa == 3'd4) begin
                    o.m = r.y;
                end else begin
                    cmp_r = aaa[0] ? r.x : r.y;
                    sum = {1'b0, cmp_r} + {1'b0, ~v} + 9'd1;
                    o.p[0] = sum[8];
                    o.p = set_zn(o.p, sum[7:0]);
                end
            end
        endcase
        return o;
    endfunction

endpackage

>>> rtl/cpu_6502_instruction_step.sv
// Top level of the 6502 step block: sequencer, datapath and memory.
// From the accepting cycle to the strobe: a byte write, or an execute while jammed or at the
// stop address, goes straight to S_FIN; others first walk their states (one access a cycle).
// Handshake: the next word is accepted in the cycle after the strobe; busy is high meanwhile.
// The result shows for one cycle with o_strobe; the receiver cannot stall.
// Reset clears the registers to their reset values; memory is not cleared.
module cpu_6502_instruction_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  c65_pkg::t_in_word  i_cmd,
    output logic               o_strobe,
    output c65_pkg::t_out_word o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import c65_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    assign o_cfg_ready = !busy;

    c65_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_cmd.mode),
        .i_stat   (stat),
        .o_cmd    (ctl),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    c65_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_ctl      (ctl),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_result   (o_result)
    );
endmodule

>>> rtl/c65_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module c65_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/c65_ctrl.sv
// Sequencer for the 6502 step block: walks each request through its memory
// cycles and issues one micro-operation a cycle. Depends on c65_pkg.
module c65_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [2:0]        i_mode,
    input  c65_pkg::t_dp_stat i_stat,
    output c65_pkg::t_dp_cmd  o_cmd,
    output logic              busy,
    output logic              o_strobe
);
    import c65_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_mode)
                        MODE_READ:  n_state = S_HRD;
                        MODE_EXEC:  n_state = (i_stat.jam || i_stat.at_stop) ? S_FIN : S_OP;
                        MODE_RESET: n_state = S_V1;
                        MODE_START: n_state = S_ST2;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_HRD: n_state = S_FIN;
            S_V1:  n_state = S_V2;
            S_V2:  n_state = S_FIN;
            S_ST2: n_state = S_FIN;
            S_OP: begin
                unique case (i_stat.cls)
                    CL_IMPL, CL_JAM, CL_PUSH: n_state = S_FIN;
                    CL_PULL, CL_RTS, CL_RTI:  n_state = S_PL;
                    CL_BRK:                   n_state = S_BK2;
                    default:                  n_state = S_B1;
                endcase
            end
            S_PL: begin
                unique case (i_stat.cls)
                    CL_RTS:  n_state = S_PH;
                    CL_RTI:  n_state = S_PL2;
                    default: n_state = S_FIN;
                endcase
            end
            S_PL2: n_state = S_PH;
            S_PH:  n_state = S_FIN;
            S_BK2: n_state = S_BK3;
            S_BK3: n_state = S_BK4;
            S_BK4: n_state = S_V1;
            S_B1: begin
                priority if (i_stat.cls == CL_BRANCH || i_stat.am == AM_IMM) begin
                    n_state = S_FIN;
                end else if (i_stat.am == AM_ZP || i_stat.am == AM_ZPX
                             || i_stat.am == AM_ZPY) begin
                    n_state = S_ACC;
                end else if (i_stat.am == AM_INDX || i_stat.am == AM_INDY) begin
                    n_state = S_P1;
                end else begin
                    n_state = S_B2;
                end
            end
            S_B2: begin
                unique case (i_stat.cls)
                    CL_JMP:  n_state = S_FIN;
                    CL_JSR:  n_state = S_JS2;
                    CL_JMPI: n_state = S_I1;
                    default: n_state = S_ACC;
                endcase
            end
            S_JS2: n_state = S_FIN;
            S_I1:  n_state = S_I2;
            S_I2:  n_state = S_FIN;
            S_P1:  n_state = S_P2;
            S_P2:  n_state = S_ACC;
            S_ACC: n_state = (i_stat.cls == CL_STORE) ? S_FIN : S_OPND;
            S_OPND: n_state = S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.op_load = 1'b0;
        o_cmd.uop = U_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_mode)
                        MODE_WRITE: o_cmd.uop = U_HWRITE;
                        MODE_READ:  o_cmd.uop = U_HREAD;
                        MODE_EXEC: begin
                            priority if (i_stat.jam) begin
                                o_cmd.uop = U_JAMST;
                            end else if (i_stat.at_stop) begin
                                o_cmd.uop = U_STOPST;
                            end else begin
                                o_cmd.uop = U_FETCH;
                            end
                        end
                        MODE_RESET: o_cmd.uop = U_RST;
                        MODE_START: o_cmd.uop = U_START1;
                        default:    o_cmd.uop = U_NONE;
                    endcase
                end
            end
            S_HRD: o_cmd.uop = U_HLATCH;
            S_V1:  o_cmd.uop = U_VLO;
            S_V2:  o_cmd.uop = U_VHI;
            S_ST2: o_cmd.uop = U_START2;
            S_OP: begin
                o_cmd.op_load = 1'b1;
                unique case (i_stat.cls)
                    CL_IMPL:                 o_cmd.uop = U_IMPL;
                    CL_JAM:                  o_cmd.uop = U_JAM;
                    CL_PUSH:                 o_cmd.uop = U_PUSH;
                    CL_PULL, CL_RTS, CL_RTI: o_cmd.uop = U_POP;
                    CL_BRK:                  o_cmd.uop = U_BRK1;
                    default:                 o_cmd.uop = U_FETCH;
                endcase
            end
            S_PL: begin
                unique case (i_stat.cls)
                    CL_RTS:  o_cmd.uop = U_POPLO;
                    CL_RTI:  o_cmd.uop = U_POPP;
                    default: o_cmd.uop = U_PULL;
                endcase
            end
            S_PL2: o_cmd.uop = U_POPLO;
            S_PH:  o_cmd.uop = U_RET;
            S_BK2: o_cmd.uop = U_BRK2;
            S_BK3: o_cmd.uop = U_BRK3;
            S_BK4: o_cmd.uop = U_VEC;
            S_B1: begin
                priority if (i_stat.cls == CL_BRANCH) begin
                    o_cmd.uop = U_BRANCH;
                end else if (i_stat.am == AM_IMM) begin
                    o_cmd.uop = U_EXEC;
                end else if (i_stat.am == AM_ZP || i_stat.am == AM_ZPX
                             || i_stat.am == AM_ZPY) begin
                    o_cmd.uop = U_ZP;
                end else if (i_stat.am == AM_INDX || i_stat.am == AM_INDY) begin
                    o_cmd.uop = U_PTR;
                end else begin
                    o_cmd.uop = U_FETCH;
                end
            end
            S_B2: begin
                unique case (i_stat.cls)
                    CL_JMP:  o_cmd.uop = U_JMP;
                    CL_JSR:  o_cmd.uop = U_JSR1;
                    CL_JMPI: o_cmd.uop = U_IND1;
                    default: o_cmd.uop = U_ABS;
                endcase
            end
            S_JS2: o_cmd.uop = U_JSR2;
            S_I1:  o_cmd.uop = U_IND2;
            S_I2:  o_cmd.uop = U_IND3;
            S_P1:  o_cmd.uop = U_PTR2;
            S_P2:  o_cmd.uop = U_PTR3;
            S_ACC: o_cmd.uop = (i_stat.cls == CL_STORE) ? U_STORE : U_RDEA;
            S_OPND: o_cmd.uop = (i_stat.cls == CL_RMW) ? U_RMW : U_EXEC;
            default: o_cmd.uop = U_NONE;
        endcase
    end

    assign busy = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_FIN);
endmodule

>>> rtl/c65_dp.sv
// Datapath of the 6502 step block: architectural registers, address and
// operand temporaries, the 64 KiB memory and the execute logic.
// Depends on c65_pkg and c65_ram.
module c65_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c65_pkg::t_in_word  i_cmd,
    input  c65_pkg::t_dp_cmd   i_ctl,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output c65_pkg::t_dp_stat  o_stat,
    output c65_pkg::t_out_word o_result
);
    import c65_pkg::*;

    logic [7:0]  r_a, r_x, r_y, r_s, r_p;
    logic [7:0]  n_a, n_x, n_y, n_s, n_p;
    logic [15:0] r_pc, n_pc;
    logic        r_jam, n_jam;
    logic [15:0] r_stop;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_val, n_val;
    logic [15:0] r_ea, n_ea;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_rdata, n_rdata;

    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_q;

    logic [7:0]  op_cur;
    t_dec        dec;
    t_regs       regs_in;
    t_regs       ex;
    logic [7:0]  ex_v;
    logic [7:0]  idx;
    logic [7:0]  ptr;
    logic [15:0] pc_inc;
    logic [15:0] pc_dec;
    logic        br_flag;

    c65_ram #(
        .WIDTH(8),
        .DEPTH(65536)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_q)
    );

    assign op_cur = i_ctl.op_load ? mem_q : r_op;
    assign dec = decode(op_cur);
    assign regs_in = '{a: r_a, x: r_x, y: r_y, s: r_s, p: r_p, m: 8'h00};
    assign ex_v = (i_ctl.uop == U_IMPL) ? r_a : mem_q;
    assign ex = exec_op(op_cur, ex_v, regs_in);
    assign pc_inc = r_pc + 16'd1;
    assign pc_dec = r_pc - 16'd1;
    assign ptr = mem_q + ((dec.am == AM_INDX) ? r_x : 8'h00);

    always_comb begin
        unique case (dec.am)
            AM_ZPX, AM_ABSX: idx = r_x;
            AM_ZPY, AM_ABSY: idx = r_y;
            default:         idx = 8'h00;
        endcase
        unique case (op_cur[7:6])
            2'd0: br_flag = r_p[7];
            2'd1: br_flag = r_p[6];
            2'd2: br_flag = r_p[0];
            default: br_flag = r_p[1];
        endcase
    end

    always_comb begin
        n_a = r_a;
        n_x = r_x;
        n_y = r_y;
        n_s = r_s;
        n_p = r_p;
        n_pc = r_pc;
        n_jam = r_jam;
        n_op = i_ctl.op_load ? mem_q : r_op;
        n_lo = r_lo;
        n_val = r_val;
        n_ea = r_ea;
        n_status = i_ctl.accept ? ST_DONE : r_status;
        n_rdata = i_ctl.accept ? 8'h00 : r_rdata;
        mem_we = 1'b0;
        mem_addr = r_pc;
        mem_wdata = 8'h00;
        unique case (i_ctl.uop)
            U_HWRITE: begin
                mem_we = 1'b1;
                mem_addr = i_cmd.address;
                mem_wdata = i_cmd.data;
            end
            U_HREAD:  mem_addr = i_cmd.address;
            U_HLATCH: n_rdata = mem_q;
            U_JAMST:  n_status = ST_JAM;
            U_STOPST: n_status = ST_STOP;
            U_FETCH: begin
                mem_addr = r_pc;
                n_pc = pc_inc;
                n_lo = mem_q;
            end
            U_RST: begin
                n_a = 8'h00;
                n_x = 8'h00;
                n_y = 8'h00;
                n_s = 8'hFF;
                n_p = P_RESET;
                n_jam = 1'b0;
                n_ea = VEC_RESET;
                mem_addr = VEC_RESET;
            end
            U_VEC: mem_addr = r_ea;
            U_VLO: begin
                n_val = mem_q;
                mem_addr = {r_ea[15:1], 1'b1};
            end
            U_VHI: n_pc = {mem_q, r_val};
            U_START1: begin
                mem_we = 1'b1;
                mem_addr = {8'h01, 8'hFF};
                mem_wdata = RET_HI;
                n_s = SP_START;
                n_pc = i_cmd.address;
                n_jam = 1'b0;
            end
            U_START2: begin
                mem_we = 1'b1;
                mem_addr = {8'h01, 8'hFE};
                mem_wdata = RET_LO;
            end
            U_IMPL: begin
                n_a = ex.a;
                n_x = ex.x;
                n_y = ex.y;
                n_s = ex.s;
                n_p = ex.p;
            end
            U_JAM: begin
                n_pc = pc_dec;
                n_jam = 1'b1;
                n_status = ST_JAM;
            end
            U_PUSH: begin
                mem_we = 1'b1;
                mem_addr = {8'h01, r_s};
                mem_wdata = (op_cur == OP_PHA) ? r_a : r_p;
                n_s = r_s - 8'd1;
            end
            U_POP: begin
                n_s = r_s + 8'd1;
                mem_addr = {8'h01, n_s};
            end
            U_PULL: begin
                if (r_op == OP_PLA) begin
                    n_a = mem_q;
                    n_p = set_zn(r_p, mem_q);
                end else begin
                    n_p = mem_q;
                end
            end
            U_POPLO: begin
                n_val = mem_q;
                n_s = r_s + 8'd1;
                mem_addr = {8'h01, n_s};
            end
            U_POPP: begin
                n_p = mem_q;
                n_s = r_s + 8'd1;
                mem_addr = {8'h01, n_s};
            end
            U_RET: n_pc = {mem_q, r_val} + ((r_op == OP_RTS) ? 16'd1 : 16'd0);
            U_BRK1: begin
                n_pc = pc_inc;
                mem_we = 1'b1;
                mem_addr = {8'h01, r_s};
                mem_wdata = pc_inc[15:8];
                n_s = r_s - 8'd1;
                n_status = ST_BRK;
            end
            U_BRK2: begin
                mem_we = 1'b1;
                mem_addr = {8'h01, r_s};
                mem_wdata = r_pc[7:0];
                n_s = r_s - 8'd1;
            end
            U_BRK3: begin
                mem_we = 1'b1;
                mem_addr = {8'h01, r_s};
                mem_wdata = r_p | 8'h10;
                n_s = r_s - 8'd1;
                n_p = r_p | 8'h04;
                n_ea = VEC_BRK;
            end
            U_BRANCH: begin
                if (br_flag == op_cur[5]) begin
                    n_pc = r_pc + {{8{mem_q[7]}}, mem_q};
                end
            end
            U_EXEC: begin
                n_a = ex.a;
                n_x = ex.x;
                n_y = ex.y;
                n_p = ex.p;
            end
            U_ZP: n_ea = {8'h00, mem_q + idx};
            U_PTR: begin
                n_lo = ptr;
                mem_addr = {8'h00, ptr};
            end
            U_PTR2: begin
                n_val = mem_q;
                mem_addr = {8'h00, r_lo + 8'd1};
            end
            U_PTR3: n_ea = {mem_q, r_val} + {8'h00, (dec.am == AM_INDY) ? r_y : 8'h00};
            U_JMP: n_pc = {mem_q, r_lo};
            U_JSR1: begin
                n_ea = {mem_q, r_lo};
                mem_we = 1'b1;
                mem_addr = {8'h01, r_s};
                mem_wdata = pc_dec[15:8];
                n_s = r_s - 8'd1;
            end
            U_JSR2: begin
                mem_we = 1'b1;
                mem_addr = {8'h01, r_s};
                mem_wdata = pc_dec[7:0];
                n_s = r_s - 8'd1;
                n_pc = r_ea;
            end
            U_IND1: begin
                n_ea = {mem_q, r_lo};
                mem_addr = {mem_q, r_lo};
            end
            U_IND2: begin
                n_val = mem_q;
                mem_addr = {r_ea[15:8], r_ea[7:0] + 8'd1};
            end
            U_IND3: n_pc = {mem_q, r_val};
            U_ABS: n_ea = {mem_q, r_lo} + {8'h00, idx};
            U_STORE: begin
                mem_we = 1'b1;
                mem_addr = r_ea;
                mem_wdata = ex.m;
            end
            U_RDEA: mem_addr = r_ea;
            U_RMW: begin
                mem_we = 1'b1;
                mem_addr = r_ea;
                mem_wdata = ex.m;
                n_p = ex.p;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 8'h00;
            r_x <= 8'h00;
            r_y <= 8'h00;
            r_s <= 8'hFF;
            r_p <= P_RESET;
            r_pc <= 16'h0000;
            r_jam <= 1'b0;
            r_stop <= STOP_RESET;
            r_status <= ST_DONE;
            r_rdata <= 8'h00;
        end else begin
            r_a <= n_a;
            r_x <= n_x;
            r_y <= n_y;
            r_s <= n_s;
            r_p <= n_p;
            r_pc <= n_pc;
            r_jam <= n_jam;
            r_status <= n_status;
            r_rdata <= n_rdata;
            if (i_cfg_we) begin
                r_stop <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_lo <= n_lo;
        r_val <= n_val;
        r_ea <= n_ea;
    end

    assign o_stat.cls = dec.cls;
    assign o_stat.am = dec.am;
    assign o_stat.jam = r_jam;
    assign o_stat.at_stop = (r_pc == r_stop);

    assign o_result.status = r_status;
    assign o_result.read_data = r_rdata;
    assign o_result.program_counter = r_pc;
    assign o_result.accumulator = r_a;
    assign o_result.index_x = r_x;
    assign o_result.index_y = r_y;
    assign o_result.stack_pointer = r_s;
    assign o_result.status_flags = r_p;
endmodule

>>> tb/sv/c65_step_checker.sv
// Checker for the 6502 instruction step block: predicts every result word from
// the accepted command words and configuration writes, and compares them.
// Depends on c65_pkg for the payload types, modes, status codes and vectors.
`timescale 1ns / 1ps

module c65_step_checker
    import c65_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_cmd,
    input  logic      i_strobe,
    input  t_out_word i_result,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int        o_errors,
    output logic      o_drained
);

    localparam logic [7:0] OP_NOP_IMM = 8'h89;
    localparam logic [7:0] OP_BIT_ZP  = 8'h24;
    localparam logic [7:0] OP_JMP     = 8'h4C;
    localparam logic [7:0] OP_JMP_IND = 8'h6C;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_RTI     = 8'h40;
    localparam logic [7:0] OP_BRK     = 8'h00;
    localparam logic [7:0] OP_NOP     = 8'hEA;
    localparam logic [7:0] OP_CLC     = 8'h18;
    localparam logic [7:0] OP_SEC     = 8'h38;
    localparam logic [7:0] OP_CLI     = 8'h58;
    localparam logic [7:0] OP_SEI     = 8'h78;
    localparam logic [7:0] OP_CLV     = 8'hB8;
    localparam logic [7:0] OP_CLD     = 8'hD8;
    localparam logic [7:0] OP_SED     = 8'hF8;
    localparam logic [7:0] OP_PHP     = 8'h08;
    localparam logic [7:0] OP_PLP     = 8'h28;
    localparam logic [7:0] OP_TAX     = 8'hAA;
    localparam logic [7:0] OP_TAY     = 8'hA8;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_TYA     = 8'h98;
    localparam logic [7:0] OP_TSX     = 8'hBA;
    localparam logic [7:0] OP_TXS     = 8'h9A;
    localparam logic [7:0] OP_INX     = 8'hE8;
    localparam logic [7:0] OP_INY     = 8'hC8;
    localparam logic [7:0] OP_DEX     = 8'hCA;
    localparam logic [7:0] OP_DEY     = 8'h88;

    localparam t_am G1_AM [0:7] = '{AM_INDX, AM_ZP, AM_IMM, AM_ABS, AM_INDY, AM_ZPX,
                                    AM_ABSY, AM_ABSX};

    logic [7:0]  mem_img [0:65535];
    logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
    logic [15:0] pc_q, stop_q;
    logic        jam_q;
    t_out_word   result_q [$];
    int          n_err = 0;

    assign o_errors  = n_err;
    assign o_drained = (result_q.size() == 0);

    function automatic logic [7:0] fetch_b();
        logic [7:0] v;
        v = mem_img[pc_q];
        pc_q = pc_q + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] fetch_w();
        logic [7:0] lo;
        logic [7:0] hi;
        lo = fetch_b();
        hi = fetch_b();
        return {hi, lo};
    endfunction

    function automatic logic [15:0] zp_word(logic [7:0] z);
        logic [7:0] z1;
        z1 = z + 8'd1;
        return {mem_img[{8'h00, z1}], mem_img[{8'h00, z}]};
    endfunction

    function automatic void push_b(logic [7:0] v);
        mem_img[{8'h01, sp_q}] = v;
        sp_q = sp_q - 8'd1;
    endfunction

    function automatic logic [7:0] pop_b();
        sp_q = sp_q + 8'd1;
        return mem_img[{8'h01, sp_q}];
    endfunction

    function automatic void upd_zn(logic [7:0] v);
        p_q[1] = (v == 8'h00);
        p_q[7] = v[7];
    endfunction

    function automatic t_am plain_am(logic [2:0] bbb, logic uses_y);
        case (bbb)
            3'd0: return AM_IMM;
            3'd1: return AM_ZP;
            3'd3: return AM_ABS;
            3'd5: return uses_y ? AM_ZPY : AM_ZPX;
            default: return uses_y ? AM_ABSY : AM_ABSX;
        endcase
    endfunction

    function automatic logic [15:0] ea_of(t_am am);
        logic [7:0]  z;
        logic [15:0] b;
        case (am)
            AM_INDX: begin
                z = fetch_b() + x_q;
                return zp_word(z);
            end
            AM_ZP: return {8'h00, fetch_b()};
            AM_IMM: begin
                b = pc_q;
                pc_q = pc_q + 16'd1;
                return b;
            end
            AM_ABS: return fetch_w();
            AM_INDY: begin
                z = fetch_b();
                return zp_word(z) + {8'h00, y_q};
            end
            AM_ZPX: begin
                z = fetch_b() + x_q;
                return {8'h00, z};
            end
            AM_ABSY: return fetch_w() + {8'h00, y_q};
            AM_ABSX: return fetch_w() + {8'h00, x_q};
            default: begin
                z = fetch_b() + y_q;
                return {8'h00, z};
            end
        endcase
    endfunction

    function automatic void compare_to(logic [7:0] r, logic [7:0] v);
        p_q[0] = (r >= v);
        upd_zn(r - v);
    endfunction

    function automatic void add_carry(logic [7:0] v);
        logic [8:0] sum;
        logic [7:0] t;
        sum = {1'b0, a_q} + {1'b0, v} + {8'h00, p_q[0]};
        t = ~(a_q ^ v) & (a_q ^ sum[7:0]);
        p_q[0] = sum[8];
        p_q[6] = t[7];
        a_q = sum[7:0];
        upd_zn(a_q);
    endfunction

    function automatic void sub_borrow(logic [7:0] v);
        logic       bw;
        logic [7:0] r;
        logic [7:0] t;
        bw = ~p_q[0];
        r = a_q - v - {7'd0, bw};
        t = (a_q ^ r) & (a_q ^ v);
        p_q[0] = ({1'b0, a_q} >= {1'b0, v} + {8'd0, bw});
        p_q[6] = t[7];
        a_q = r;
        upd_zn(r);
    endfunction

    // Kind follows the opcode row: ASL, ROL, LSR, ROR.
    function automatic logic [7:0] shifted(logic [1:0] kind, logic [7:0] v);
        logic [7:0] r;
        logic       c;
        c = p_q[0];
        case (kind)
            2'd0: r = {v[6:0], 1'b0};
            2'd1: r = {v[6:0], c};
            2'd2: r = {1'b0, v[7:1]};
            default: r = {c, v[7:1]};
        endcase
        p_q[0] = kind[1] ? v[0] : v[7];
        upd_zn(r);
        return r;
    endfunction

    function automatic logic [1:0] run_instr();
        logic [7:0]  op;
        logic [7:0]  v;
        logic [7:0]  off;
        logic [2:0]  aaa;
        logic [2:0]  bbb;
        logic [1:0]  cc;
        logic [15:0] ea;
        logic [15:0] ptr;
        logic        flag_set;
        if (jam_q) return ST_JAM;
        if (pc_q == stop_q) return ST_STOP;
        op = fetch_b();
        aaa = op[7:5];
        bbb = op[4:2];
        cc = op[1:0];
        if (cc == 2'd1 && op != OP_NOP_IMM) begin
            ea = ea_of(G1_AM[bbb]);
            v = mem_img[ea];
            case (aaa)
                3'd0: begin a_q = a_q | v; upd_zn(a_q); end
                3'd1: begin a_q = a_q & v; upd_zn(a_q); end
                3'd2: begin a_q = a_q ^ v; upd_zn(a_q); end
                3'd3: add_carry(v);
                3'd4: mem_img[ea] = a_q;
                3'd5: begin a_q = v; upd_zn(v); end
                3'd6: compare_to(a_q, v);
                default: sub_borrow(v);
            endcase
            return ST_DONE;
        end
        if (cc == 2'd2 && !aaa[2] && bbb inside {3'd1, 3'd2, 3'd3, 3'd5, 3'd7}) begin
            if (bbb == 3'd2) begin
                a_q = shifted(aaa[1:0], a_q);
            end else begin
                ea = ea_of(plain_am(bbb, 1'b0));
                mem_img[ea] = shifted(aaa[1:0], mem_img[ea]);
            end
            return ST_DONE;
        end
        if (cc == 2'd2 && aaa[2:1] == 2'b11 && bbb[0]) begin
            ea = ea_of(plain_am(bbb, 1'b0));
            v = aaa[0] ? mem_img[ea] + 8'd1 : mem_img[ea] - 8'd1;
            mem_img[ea] = v;
            upd_zn(v);
            return ST_DONE;
        end
        if (cc == 2'd2 && aaa == 3'd5 && bbb inside {3'd0, 3'd1, 3'd3, 3'd5, 3'd7}) begin
            x_q = mem_img[ea_of(plain_am(bbb, 1'b1))];
            upd_zn(x_q);
            return ST_DONE;
        end
        if (cc == 2'd2 && aaa == 3'd4 && bbb inside {3'd1, 3'd3, 3'd5}) begin
            mem_img[ea_of(plain_am(bbb, 1'b1))] = x_q;
            return ST_DONE;
        end
        if (cc == 2'd0 && aaa == 3'd5 && bbb inside {3'd0, 3'd1, 3'd3, 3'd5, 3'd7}) begin
            y_q = mem_img[ea_of(plain_am(bbb, 1'b0))];
            upd_zn(y_q);
            return ST_DONE;
        end
        if (cc == 2'd0 && aaa == 3'd4 && bbb inside {3'd1, 3'd3, 3'd5}) begin
            mem_img[ea_of(plain_am(bbb, 1'b0))] = y_q;
            return ST_DONE;
        end
        if (cc == 2'd0 && aaa[2:1] == 2'b11 && bbb inside {3'd0, 3'd1, 3'd3}) begin
            v = mem_img[ea_of(plain_am(bbb, 1'b0))];
            compare_to(aaa[0] ? x_q : y_q, v);
            return ST_DONE;
        end
        if (op[4:0] == 5'h10) begin
            off = fetch_b();
            case (aaa[2:1])
                2'd0: flag_set = p_q[7];
                2'd1: flag_set = p_q[6];
                2'd2: flag_set = p_q[0];
                default: flag_set = p_q[1];
            endcase
            if (flag_set == aaa[0]) pc_q = pc_q + {{8{off[7]}}, off};
            return ST_DONE;
        end
        case (op)
            OP_BIT_ZP: begin
                v = mem_img[{8'h00, fetch_b()}];
                p_q[1] = ((a_q & v) == 8'h00);
                p_q[7:6] = v[7:6];
            end
            OP_JMP: pc_q = fetch_w();
            OP_JMP_IND: begin
                ptr = fetch_w();
                v = ptr[7:0] + 8'd1;
                pc_q = {mem_img[{ptr[15:8], v}], mem_img[ptr]};
            end
            OP_JSR: begin
                ea = fetch_w();
                ptr = pc_q - 16'd1;
                push_b(ptr[15:8]);
                push_b(ptr[7:0]);
                pc_q = ea;
            end
            OP_RTS: begin
                ptr[7:0] = pop_b();
                ptr[15:8] = pop_b();
                pc_q = ptr + 16'd1;
            end
            OP_RTI: begin
                p_q = pop_b();
                ptr[7:0] = pop_b();
                ptr[15:8] = pop_b();
                pc_q = ptr;
            end
            OP_BRK: begin
                pc_q = pc_q + 16'd1;
                push_b(pc_q[15:8]);
                push_b(pc_q[7:0]);
                push_b(p_q | 8'h10);
                p_q[2] = 1'b1;
                pc_q = {mem_img[VEC_BRK + 16'd1], mem_img[VEC_BRK]};
                return ST_BRK;
            end
            OP_NOP: ;
            OP_CLC: p_q[0] = 1'b0;
            OP_SEC: p_q[0] = 1'b1;
            OP_CLI: p_q[2] = 1'b0;
            OP_SEI: p_q[2] = 1'b1;
            OP_CLV: p_q[6] = 1'b0;
            OP_CLD: p_q[3] = 1'b0;
            OP_SED: p_q[3] = 1'b1;
            OP_PHA: push_b(a_q);
            OP_PHP: push_b(p_q);
            OP_PLA: begin a_q = pop_b(); upd_zn(a_q); end
            OP_PLP: p_q = pop_b();
            OP_TAX: begin x_q = a_q; upd_zn(x_q); end
            OP_TAY: begin y_q = a_q; upd_zn(y_q); end
            OP_TXA: begin a_q = x_q; upd_zn(a_q); end
            OP_TYA: begin a_q = y_q; upd_zn(a_q); end
            OP_TSX: begin x_q = sp_q; upd_zn(x_q); end
            OP_TXS: sp_q = x_q;
            OP_INX: begin x_q = x_q + 8'd1; upd_zn(x_q); end
            OP_INY: begin y_q = y_q + 8'd1; upd_zn(y_q); end
            OP_DEX: begin x_q = x_q - 8'd1; upd_zn(x_q); end
            OP_DEY: begin y_q = y_q - 8'd1; upd_zn(y_q); end
            default: begin
                pc_q = pc_q - 16'd1;
                jam_q = 1'b1;
                return ST_JAM;
            end
        endcase
        return ST_DONE;
    endfunction

    function automatic void clear_core();
        a_q = 8'h00;
        x_q = 8'h00;
        y_q = 8'h00;
        sp_q = 8'hFF;
        p_q = P_RESET;
        jam_q = 1'b0;
    endfunction

    function automatic t_out_word step_word(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.mode)
            MODE_WRITE: mem_img[w.address] = w.data;
            MODE_READ: r.read_data = mem_img[w.address];
            MODE_EXEC: r.status = run_instr();
            MODE_RESET: begin
                clear_core();
                pc_q = {mem_img[VEC_RESET + 16'd1], mem_img[VEC_RESET]};
            end
            MODE_START: begin
                mem_img[16'h01FF] = RET_HI;
                mem_img[16'h01FE] = RET_LO;
                sp_q = SP_START;
                pc_q = w.address;
                jam_q = 1'b0;
            end
            default: ;
        endcase
        r.program_counter = pc_q;
        r.accumulator = a_q;
        r.index_x = x_q;
        r.index_y = y_q;
        r.stack_pointer = sp_q;
        r.status_flags = p_q;
        return r;
    endfunction

    task automatic check_field(input string nm, input logic [15:0] e, input logic [15:0] g);
        if (e !== g) begin
            n_err++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, nm, e, g);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            clear_core();
            pc_q = 16'h0000;
            stop_q = STOP_RESET;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) stop_q = i_cfg_data;
            if (i_start && !i_busy) result_q.push_back(step_word(i_cmd));
            if (i_strobe) begin
                if (result_q.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected result word: expected none, actual %h",
                             $time, i_result);
                end else begin
                    e = result_q.pop_front();
                    check_field("status", e.status, i_result.status);
                    check_field("read_data", e.read_data, i_result.read_data);
                    check_field("program_counter", e.program_counter,
                                i_result.program_counter);
                    check_field("accumulator", e.accumulator, i_result.accumulator);
                    check_field("index_x", e.index_x, i_result.index_x);
                    check_field("index_y", e.index_y, i_result.index_y);
                    check_field("stack_pointer", e.stack_pointer, i_result.stack_pointer);
                    check_field("status_flags", e.status_flags, i_result.status_flags);
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_cpu_6502_instruction_step.sv
// Testbench top for the 6502 instruction step block: drives command words and
// stop address writes, and reports the verdict from the checker's error count.
// Depends on c65_pkg, cpu_6502_instruction_step and c65_step_checker.
`timescale 1ns / 1ps

module tb_cpu_6502_instruction_step;
    import c65_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam logic [7:0] OP_NOP = 8'hEA;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    i_cmd = '0;
    logic        o_strobe;
    t_out_word   o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;
    int          n_err;
    logic        drained;
    int          cycles = 0;
    logic        quiet = 1'b0;
    logic [15:0] last_wr = 16'h0000;

    always #6 i_clk = ~i_clk;

    cpu_6502_instruction_step uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    c65_step_checker step_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_cmd(i_cmd),
        .i_strobe(o_strobe), .i_result(o_result), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data), .o_errors(n_err),
        .o_drained(drained)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_word(input logic [2:0] m, input logic [15:0] ad, input logic [7:0] d);
        @(negedge i_clk);
        start = 1'b1;
        i_cmd.mode = m;
        i_cmd.address = ad;
        i_cmd.data = d;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 16)) @(negedge i_clk);
    endtask

    // Lays down the instruction bytes at the predicted PC, plus a pointer in
    // zero page for the indirect modes, so that every access hits written memory.
    task automatic run_op(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2);
        logic [15:0] pc;
        logic [7:0]  zl;
        logic [7:0]  zh;
        logic [15:0] pa;
        logic        clash;
        pc = step_chk.pc_q;
        clash = 1'b0;
        if (op[1:0] == 2'd1 && (op[4:2] == 3'd0 || op[4:2] == 3'd4)) begin
            zl = (op[4:2] == 3'd0) ? b1 + step_chk.x_q : b1;
            zh = zl + 8'd1;
            for (int k = 0; k < 3; k++) begin
                pa = pc + k[15:0];
                if (pa == {8'h00, zl} || pa == {8'h00, zh}) clash = 1'b1;
            end
            if (clash) begin
                op = OP_NOP;
            end else begin
                put_word(MODE_WRITE, {8'h00, zl}, 8'($urandom));
                put_word(MODE_WRITE, {8'h00, zh}, 8'h00);
            end
        end
        put_word(MODE_WRITE, pc, op);
        put_word(MODE_WRITE, pc + 16'd1, b1);
        put_word(MODE_WRITE, pc + 16'd2, b2);
        maybe_gap();
        put_word(MODE_EXEC, 16'($urandom), 8'($urandom));
    endtask

    task automatic write_stop(input logic [15:0] v);
        while (!drained) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_phase(input int count, input int quiet_from);
        int          sel;
        logic [15:0] ad;
        for (int n = 0; n < count; n++) begin
            quiet = (n >= quiet_from);
            sel = $urandom_range(0, 99);
            if (step_chk.jam_q && $urandom_range(0, 2) != 0) sel = ($urandom_range(0, 3) == 0) ? 95 : 90;
            if (sel < 70) begin
                run_op(8'($urandom), 8'($urandom), 8'h00);
            end else if (sel < 78) begin
                ad = ($urandom_range(0, 1) == 1) ? last_wr
                     : {8'($urandom_range(0, 1)), 8'($urandom)};
                put_word(MODE_READ, ad, 8'($urandom));
            end else if (sel < 86) begin
                last_wr = 16'($urandom);
                put_word(MODE_WRITE, last_wr, 8'($urandom));
            end else if (sel < 93) begin
                ad = ($urandom_range(0, 4) == 0) ? step_chk.stop_q : 16'($urandom);
                put_word(MODE_START, ad, 8'($urandom));
            end else if (sel < 97) begin
                put_word(MODE_RESET, 16'($urandom), 8'($urandom));
            end else begin
                put_word(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom));
            end
            maybe_gap();
        end
    endtask

    initial begin
        logic [7:0] dir_ops [0:16];
        logic [7:0] dir_b1 [0:16];
        logic [7:0] dir_b2 [0:16];
        // LDX #, LDA abs,X wrapping at 16 bits, LDY #, LDA (zp),Y, LDA #7F, ADC
        // overflow, SBC, CMP, JMP (ind) across a page end, JSR, RTS, PHP, PLP,
        // BRK, RTI, an unknown opcode and a second execute while jammed.
        dir_ops = '{8'hA2, 8'hBD, 8'hA0, 8'hB1, 8'hA9, 8'h69, 8'hE9, 8'hC9, 8'h6C, 8'h20,
                    8'h60, 8'h08, 8'h28, 8'h00, 8'h40, 8'h02, 8'h02};
        dir_b1 = '{8'h10, 8'hF8, 8'h20, 8'h40, 8'h7F, 8'h01, 8'h80, 8'h7F, 8'hFF, 8'h30,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        dir_b2 = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int a = 0; a < 512; a++) put_word(MODE_WRITE, 16'(a), 8'($urandom));
        for (int a = 16'hFFFC; a <= 16'hFFFF; a++) put_word(MODE_WRITE, 16'(a), 8'($urandom));

        put_word(MODE_START, 16'h0400, 8'h00);
        for (int k = 0; k < 17; k++) run_op(dir_ops[k], dir_b1[k], dir_b2[k]);
        put_word(MODE_RESET, 16'hFFFF, 8'hFF);
        put_word(3'd7, 16'hFFFF, 8'hFF);
        put_word(MODE_READ, 16'hFFFF, 8'h00);
        put_word(MODE_START, STOP_RESET, 8'h00);
        put_word(MODE_EXEC, 16'h0000, 8'h00);

        write_stop(16'h0000);
        random_phase(20, 1000);
        write_stop(16'hFFFF);
        random_phase(20, 1000);
        write_stop(16'($urandom));
        random_phase(20, 1000);
        write_stop(STOP_RESET);
        random_phase(25, 12);

        while (!drained) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/c65_pkg.sv
rtl/c65_ram.sv
rtl/c65_ctrl.sv
rtl/c65_dp.sv
rtl/cpu_6502_instruction_step.sv
tb/sv/c65_step_checker.sv
tb/sv/tb_cpu_6502_instruction_step.sv
